// ===== design/hsv_to_rgb_converter_core_assert.svh =====
// assertion macros for the hsv to rgb converter core
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HSV2RGB_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("hsv2rgb implication check failed");
// implication after a fixed number of cycles
`define HSV2RGB_ASSERT_DLY(label, clk, rst_n, pre, lat, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##lat (post)) \
		else $error("hsv2rgb delayed check failed");
`else
`define HSV2RGB_ASSERT_IMP(label, clk, rst_n, pre, post)
`define HSV2RGB_ASSERT_DLY(label, clk, rst_n, pre, lat, post)
`endif
`endif

// ===== design/hsv2rgb_pkg.sv =====
// shared types and constants of the hsv to rgb converter
`timescale 1ns / 1ps
`default_nettype none
package hsv2rgb_pkg;

	// width of the hue field
	localparam int HUE_W = 13;

	// 60-degree hue sectors; odd sectors have bit 0 set
	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} sector_t;

endpackage
`default_nettype wire

// ===== design/hsv2rgb_hue_split.sv =====
// two-stage hue split into sector and in-sector weight
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_hue_split import hsv2rgb_pkg::*; #(
	parameter int HUE_FRAC_BITS = 4,
	localparam int SECTOR_W = 60 << HUE_FRAC_BITS,
	localparam int TW = $clog2(SECTOR_W + 1)
) (
	input  logic                clk,
	input  logic                en_s0,
	input  logic                en_s1,
	input  logic [HUE_W-1:0]    hue,
	output sector_t             sector_s2,
	output logic [TW-1:0]       t_s2
);

	localparam int HUE_MAX = 6 * SECTOR_W;
	localparam int XW = ($clog2(HUE_MAX + 1) > HUE_W) ? $clog2(HUE_MAX + 1) : HUE_W;

	logic [XW-1:0] hue_x;
	sector_t       sec;
	logic [XW-1:0] base;
	logic          full;
	logic [TW-1:0] rem;
	sector_t       sector_s1;
	logic [TW-1:0] rem_s1;
	logic [TW-1:0] t;

	assign hue_x = XW'(hue);

	// sector by threshold compares, hue past 360 degrees pins to the last sector end
	always_comb begin
		sec  = SEC_R_TO_Y;
		base = '0;
		full = 1'b0;
		if (hue_x >= XW'(6 * SECTOR_W)) begin
			sec  = SEC_M_TO_R;
			full = 1'b1;
		end else if (hue_x >= XW'(5 * SECTOR_W)) begin
			sec  = SEC_M_TO_R;
			base = XW'(5 * SECTOR_W);
		end else if (hue_x >= XW'(4 * SECTOR_W)) begin
			sec  = SEC_B_TO_M;
			base = XW'(4 * SECTOR_W);
		end else if (hue_x >= XW'(3 * SECTOR_W)) begin
			sec  = SEC_C_TO_B;
			base = XW'(3 * SECTOR_W);
		end else if (hue_x >= XW'(2 * SECTOR_W)) begin
			sec  = SEC_G_TO_C;
			base = XW'(2 * SECTOR_W);
		end else if (hue_x >= XW'(SECTOR_W)) begin
			sec  = SEC_Y_TO_G;
			base = XW'(SECTOR_W);
		end
	end

	assign rem = full ? TW'(SECTOR_W) : TW'(hue_x - base);

	// stage 1 register
	always_ff @(posedge clk) begin
		if (en_s0) begin
			sector_s1 <= sec;
			rem_s1    <= rem;
		end
	end

	// odd sectors fall, so their weight runs backward
	assign t = sector_s1[0] ? (TW'(SECTOR_W) - rem_s1) : rem_s1;

	// stage 2 register
	always_ff @(posedge clk) begin
		if (en_s1) begin
			sector_s2 <= sector_s1;
			t_s2      <= t;
		end
	end

endmodule
`default_nettype wire

// ===== design/hsv2rgb_chroma.sv =====
// two-stage chroma: product, then rounded divide by full scale
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_chroma #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    en_s0,
	input  logic                    en_s1,
	input  logic [CHANNEL_BITS-1:0] saturation,
	input  logic [CHANNEL_BITS-1:0] brightness,
	output logic [CHANNEL_BITS-1:0] c_s2
);

	localparam int N = CHANNEL_BITS;
	localparam int CMAX = (1 << N) - 1;

	logic [2*N-1:0] p_s1;
	logic [2*N-1:0] pp;
	logic [2*N:0]   sum;

	// stage 1: brightness times saturation
	always_ff @(posedge clk) begin
		if (en_s0) begin
			p_s1 <= (2*N)'(brightness) * (2*N)'(saturation);
		end
	end

	// divide by 2^n-1 with rounding: add half, then fold the high part back in
	assign pp  = p_s1 + (2*N)'(CMAX >> 1);
	assign sum = (2*N+1)'(pp) + (2*N+1)'(pp >> N) + (2*N+1)'(1);

	// stage 2 register
	always_ff @(posedge clk) begin
		if (en_s1) begin
			c_s2 <= sum[N +: N];
		end
	end

endmodule
`default_nettype wire

// ===== design/hsv2rgb_secondary.sv =====
// two-stage secondary component: chroma times weight, then divide by sector width
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_secondary #(
	parameter int CHANNEL_BITS = 8,
	parameter int HUE_FRAC_BITS = 4,
	localparam int SECTOR_W = 60 << HUE_FRAC_BITS,
	localparam int TW = $clog2(SECTOR_W + 1)
) (
	input  logic                    clk,
	input  logic                    en_s2,
	input  logic                    en_s3,
	input  logic [CHANNEL_BITS-1:0] c_s2,
	input  logic [TW-1:0]           t_s2,
	output logic [CHANNEL_BITS-1:0] x
);

	localparam int N = CHANNEL_BITS;
	localparam int NW = N + TW;
	// sector width is 15 * 2^(frac+2): shift first, then divide by 15
	localparam int PRE_SHIFT = HUE_FRAC_BITS + 2;
	localparam int YW = NW - PRE_SHIFT;
	localparam int SHIFT = N + 8;
	localparam int unsigned RECIP = ((1 << SHIFT) + 14) / 15;
	localparam int PW = YW + SHIFT;

	logic [NW-1:0] n_s3;
	logic [YW-1:0] y;
	logic [PW-1:0] prod_s4;

	// stage 3: rounded numerator, ties go up
	always_ff @(posedge clk) begin
		if (en_s2) begin
			n_s3 <= NW'(c_s2) * NW'(t_s2) + NW'(SECTOR_W / 2);
		end
	end

	assign y = n_s3[NW-1:PRE_SHIFT];

	// stage 4: reciprocal multiply for the divide by 15
	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s4 <= PW'(y) * PW'(RECIP);
		end
	end

	assign x = prod_s4[SHIFT +: N];

endmodule
`default_nettype wire

// ===== design/hsv_to_rgb_converter_core.sv =====
// top level of the hsv to rgb converter core
// throughput: one pixel per clock, busy stays low, the pipeline never stalls
// stages: hue split and chroma product, chroma divide, secondary product,
// reciprocal divide, channel permutation with the offset added
// reset clears the valid bits only; a pixel in flight at reset is dropped
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_core_assert.svh"
module hsv_to_rgb_converter_core import hsv2rgb_pkg::*; #(
	parameter int CHANNEL_BITS = 8,
	parameter int HUE_FRAC_BITS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [HUE_W-1:0]        hue,
	input  logic [CHANNEL_BITS-1:0] saturation,
	input  logic [CHANNEL_BITS-1:0] brightness,
	input  logic [CHANNEL_BITS-1:0] alpha_in,
	output logic                    done,
	output logic [CHANNEL_BITS-1:0] red,
	output logic [CHANNEL_BITS-1:0] green,
	output logic [CHANNEL_BITS-1:0] blue,
	output logic [CHANNEL_BITS-1:0] alpha_out
);

	localparam int N = CHANNEL_BITS;
	localparam int TW = $clog2((60 << HUE_FRAC_BITS) + 1);

	logic          accept;
	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	sector_t       sector_s2, sector_s3, sector_s4;
	logic [TW-1:0] t_s2;
	logic [N-1:0]  c_s2, c_s3, c_s4;
	logic [N-1:0]  x;
	logic [N-1:0]  bri_s1, bri_s2;
	logic [N-1:0]  m_s3, m_s4;
	logic [N-1:0]  alpha_s1, alpha_s2, alpha_s3, alpha_s4;
	logic [N-1:0]  r_sel, g_sel, b_sel;
	logic [N-1:0]  red_s5, green_s5, blue_s5, alpha_s5;

	// always ready for the next transfer
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// hue to sector and weight, stages 1 and 2
	hsv2rgb_hue_split #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_hue_split (
		.clk       (clk),
		.en_s0     (accept),
		.en_s1     (v_s1),
		.hue       (hue),
		.sector_s2 (sector_s2),
		.t_s2      (t_s2)
	);

	// chroma, stages 1 and 2
	hsv2rgb_chroma #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_chroma (
		.clk        (clk),
		.en_s0      (accept),
		.en_s1      (v_s1),
		.saturation (saturation),
		.brightness (brightness),
		.c_s2       (c_s2)
	);

	// secondary component, stages 3 and 4
	hsv2rgb_secondary #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_secondary (
		.clk   (clk),
		.en_s2 (v_s2),
		.en_s3 (v_s3),
		.c_s2  (c_s2),
		.t_s2  (t_s2),
		.x     (x)
	);

	// sideband delay line and the brightness offset
	always_ff @(posedge clk) begin
		if (accept) begin
			bri_s1   <= brightness;
			alpha_s1 <= alpha_in;
		end
		if (v_s1) begin
			bri_s2   <= bri_s1;
			alpha_s2 <= alpha_s1;
		end
		if (v_s2) begin
			c_s3      <= c_s2;
			m_s3      <= bri_s2 - c_s2;
			sector_s3 <= sector_s2;
			alpha_s3  <= alpha_s2;
		end
		if (v_s3) begin
			m_s4      <= m_s3;
			sector_s4 <= sector_s3;
			alpha_s4  <= alpha_s3;
		end
	end

	// chroma aligned with stage 4
	always_ff @(posedge clk) begin
		if (v_s3) begin
			c_s4 <= c_s3;
		end
	end

	// sector permutation of chroma, secondary and zero
	always_comb begin
		r_sel = '0;
		g_sel = '0;
		b_sel = '0;
		case (sector_s4)
			SEC_R_TO_Y: begin
				r_sel = c_s4;
				g_sel = x;
			end
			SEC_Y_TO_G: begin
				r_sel = x;
				g_sel = c_s4;
			end
			SEC_G_TO_C: begin
				g_sel = c_s4;
				b_sel = x;
			end
			SEC_C_TO_B: begin
				g_sel = x;
				b_sel = c_s4;
			end
			SEC_B_TO_M: begin
				r_sel = x;
				b_sel = c_s4;
			end
			default: begin
				r_sel = c_s4;
				b_sel = x;
			end
		endcase
	end

	// stage 5: output registers with the offset added
	always_ff @(posedge clk) begin
		if (v_s4) begin
			red_s5   <= r_sel + m_s4;
			green_s5 <= g_sel + m_s4;
			blue_s5  <= b_sel + m_s4;
			alpha_s5 <= alpha_s4;
		end
	end

	assign done      = v_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;
	assign alpha_out = alpha_s5;

	// checks
	`HSV2RGB_ASSERT_DLY(a_latency, clk, arst_n, accept, 5, done && (alpha_out == $past(alpha_in, 5)))
	`HSV2RGB_ASSERT_IMP(a_done_has_source, clk, arst_n, done, $past(accept, 5))
	`HSV2RGB_ASSERT_IMP(a_chroma_in_range, clk, arst_n, v_s2, c_s2 <= bri_s2)

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the hsv to rgb converter core: directed pixel table, then random pixels
`timescale 1ns / 1ps
module tb;
	import hsv2rgb_pkg::*;

	localparam int CHANNEL_BITS  = 8;
	localparam int HUE_FRAC_BITS = 4;
	localparam int unsigned CMAX     = (1 << CHANNEL_BITS) - 1;
	localparam int unsigned SECTOR_W = 60 << HUE_FRAC_BITS;
	localparam int unsigned HUE_MAX  = 360 << HUE_FRAC_BITS;
	localparam int LATENCY       = 5;
	localparam int RANDOM_PIXELS = 400;
	localparam int QUIET_LIMIT   = 2000;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] alpha;
	} pixel_t;

	typedef struct {
		logic [HUE_W-1:0]        hue;
		logic [CHANNEL_BITS-1:0] sat;
		logic [CHANNEL_BITS-1:0] bri;
		logic [CHANNEL_BITS-1:0] alpha;
		bit                      known;
		pixel_t                  want;
	} hsv_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [HUE_W-1:0]        hue;
	logic [CHANNEL_BITS-1:0] saturation;
	logic [CHANNEL_BITS-1:0] brightness;
	logic [CHANNEL_BITS-1:0] alpha_in;
	logic                    done;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;
	logic [CHANNEL_BITS-1:0] alpha_out;

	pixel_t   pending_pixels[$];
	hsv_row_t directed_rows[$];
	bit       drv_known;
	pixel_t   drv_want;
	bit       idle_on;
	int       err_count;
	int       quiet_cycles;

	hsv_to_rgb_converter_core #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.alpha_in  (alpha_in),
		.done      (done),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha_out (alpha_out)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// fixed point hsv to rgb conversion of one pixel
	function automatic pixel_t hsv_predict(logic [HUE_W-1:0] h, logic [CHANNEL_BITS-1:0] s,
			logic [CHANNEL_BITS-1:0] v, logic [CHANNEL_BITS-1:0] a);
		int unsigned hc, rem, sv, vv, chroma, x, m, rr, gg, bb;
		sector_t sec;
		pixel_t p;
		hc = 32'(h);
		sv = 32'(s);
		vv = 32'(v);
		// hue past 360 degrees clamps to 360, the tail end of the last sector
		if (hc > HUE_MAX)
			hc = HUE_MAX;
		if (hc == HUE_MAX) begin
			sec = SEC_M_TO_R;
			rem = SECTOR_W;
		end else begin
			sec = sector_t'(hc / SECTOR_W);
			rem = hc % SECTOR_W;
		end
		chroma = (vv * sv + CMAX / 2) / CMAX;
		// odd sectors ramp down, even sectors ramp up; ties round up
		if (sec[0])
			x = (chroma * (SECTOR_W - rem) + SECTOR_W / 2) / SECTOR_W;
		else
			x = (chroma * rem + SECTOR_W / 2) / SECTOR_W;
		m = vv - chroma;
		case (sec)
			SEC_R_TO_Y: begin rr = chroma; gg = x;      bb = 0;      end
			SEC_Y_TO_G: begin rr = x;      gg = chroma; bb = 0;      end
			SEC_G_TO_C: begin rr = 0;      gg = chroma; bb = x;      end
			SEC_C_TO_B: begin rr = 0;      gg = x;      bb = chroma; end
			SEC_B_TO_M: begin rr = x;      gg = 0;      bb = chroma; end
			default:    begin rr = chroma; gg = 0;      bb = x;      end
		endcase
		p.red   = CHANNEL_BITS'(rr + m);
		p.green = CHANNEL_BITS'(gg + m);
		p.blue  = CHANNEL_BITS'(bb + m);
		p.alpha = a;
		return p;
	endfunction

	// one row of the directed table; known rows carry a hand-typed result
	task automatic add_row(int h, int s, int v, int a, bit known, int r, int g, int b);
		hsv_row_t row;
		row.hue        = HUE_W'(h);
		row.sat        = CHANNEL_BITS'(s);
		row.bri        = CHANNEL_BITS'(v);
		row.alpha      = CHANNEL_BITS'(a);
		row.known      = known;
		row.want.red   = CHANNEL_BITS'(r);
		row.want.green = CHANNEL_BITS'(g);
		row.want.blue  = CHANNEL_BITS'(b);
		row.want.alpha = CHANNEL_BITS'(a);
		directed_rows.push_back(row);
	endtask

	// drive one pixel from a falling edge and hold it until the transfer
	task automatic send_pixel(hsv_row_t row);
		while (idle_on && $urandom_range(0, 99) < 38) begin
			start      = 1'b0;
			hue        = HUE_W'($urandom);
			saturation = CHANNEL_BITS'($urandom);
			brightness = CHANNEL_BITS'($urandom);
			alpha_in   = CHANNEL_BITS'($urandom);
			@(negedge clk);
		end
		start      = 1'b1;
		hue        = row.hue;
		saturation = row.sat;
		brightness = row.bri;
		alpha_in   = row.alpha;
		drv_known  = row.known;
		drv_want   = row.want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// result check, expectation capture and watchdog
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_pixels.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("unexpected result r=%0d g=%0d b=%0d a=%0d",
							red, green, blue, alpha_out);
				end else begin
					want = pending_pixels.pop_front();
					if (red !== want.red || green !== want.green || blue !== want.blue ||
							alpha_out !== want.alpha) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display({"mismatch: expected r=%0d g=%0d b=%0d a=%0d,",
								" got r=%0d g=%0d b=%0d a=%0d"},
								want.red, want.green, want.blue, want.alpha,
								red, green, blue, alpha_out);
					end
				end
			end
			if (start && !busy)
				pending_pixels.push_back(drv_known ? drv_want :
					hsv_predict(hue, saturation, brightness, alpha_in));
		end
		if ((start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus
	initial begin
		hsv_row_t row;
		int pick, k;
		start        = 1'b0;
		hue          = '0;
		saturation   = '0;
		brightness   = '0;
		alpha_in     = '0;
		drv_known    = 1'b0;
		drv_want     = '{default: '0};
		idle_on      = 1'b1;
		err_count    = 0;
		quiet_cycles = 0;
		arst_n       = 1'b0;

		// sector starts at full chroma, clamped hues, gray and black
		add_row(0,    255, 255, 255, 1, 255, 0,   0);
		add_row(960,  255, 255, 0,   1, 255, 255, 0);
		add_row(1920, 255, 255, 128, 1, 0,   255, 0);
		add_row(2880, 255, 255, 1,   1, 0,   255, 255);
		add_row(3840, 255, 255, 254, 1, 0,   0,   255);
		add_row(4800, 255, 255, 85,  1, 255, 0,   255);
		add_row(5760, 255, 255, 170, 1, 255, 0,   0);
		add_row(5761, 255, 255, 255, 1, 255, 0,   0);
		add_row(8191, 255, 255, 0,   1, 255, 0,   0);
		add_row(4096, 0,   200, 17,  1, 200, 200, 200);
		add_row(1234, 128, 0,   99,  1, 0,   0,   0);
		add_row(0,    0,   0,   0,   1, 0,   0,   0);
		add_row(5760, 0,   255, 255, 1, 255, 255, 255);
		// rounding tie on the secondary, sector edges, mid sectors
		add_row(480,  1,   255, 60,  0, 0, 0, 0);
		add_row(959,  255, 255, 11,  0, 0, 0, 0);
		add_row(961,  255, 255, 22,  0, 0, 0, 0);
		add_row(5759, 255, 255, 33,  0, 0, 0, 0);
		add_row(2400, 128, 200, 44,  0, 0, 0, 0);
		add_row(7000, 77,  33,  55,  0, 0, 0, 0);
		add_row(1440, 255, 1,   66,  0, 0, 0, 0);
		add_row(4321, 200, 255, 77,  0, 0, 0, 0);
		add_row(3000, 255, 128, 88,  0, 0, 0, 0);
		add_row(8191, 1,   1,   170, 0, 0, 0, 0);
		add_row(6143, 170, 85,  85,  0, 0, 0, 0);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_pixel(directed_rows[i]);

		// random pixels, with one long stretch driven back to back
		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			idle_on = !(n >= 150 && n < 250);
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				row.hue = HUE_W'($urandom_range(0, HUE_MAX));
			end else if (pick < 90) begin
				k = $urandom_range(1, 6);
				row.hue = HUE_W'(k * SECTOR_W - 1 + $urandom_range(0, 2));
			end else begin
				row.hue = HUE_W'($urandom_range(HUE_MAX + 1, (1 << HUE_W) - 1));
			end
			row.sat   = ($urandom_range(0, 9) < 2) ?
				($urandom_range(0, 1) ? CHANNEL_BITS'(CMAX) : CHANNEL_BITS'(0)) :
				CHANNEL_BITS'($urandom_range(0, CMAX));
			row.bri   = ($urandom_range(0, 9) < 2) ?
				($urandom_range(0, 1) ? CHANNEL_BITS'(CMAX) : CHANNEL_BITS'(0)) :
				CHANNEL_BITS'($urandom_range(0, CMAX));
			row.alpha = CHANNEL_BITS'($urandom_range(0, CMAX));
			row.known = 1'b0;
			row.want  = '{default: '0};
			send_pixel(row);
		end
		start = 1'b0;

		// drain the pipeline, then watch for stray strobes
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY * 4) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
